>>> design/hrhp_pkg.sv
`timescale 1ns / 1ps

package hrhp_pkg;

	// Parser position within the request head
	typedef enum logic [4:0] {
		ST_METHOD_START       = 5'd0,
		ST_METHOD             = 5'd1,
		ST_URI                = 5'd2,
		ST_H                  = 5'd3,
		ST_T1                 = 5'd4,
		ST_T2                 = 5'd5,
		ST_P                  = 5'd6,
		ST_SLASH              = 5'd7,
		ST_MAJOR_START        = 5'd8,
		ST_MAJOR              = 5'd9,
		ST_MINOR_START        = 5'd10,
		ST_MINOR              = 5'd11,
		ST_LF1                = 5'd12,
		ST_LINE_START         = 5'd13,
		ST_LWS                = 5'd14,
		ST_NAME               = 5'd15,
		ST_SPACE_BEFORE_VALUE = 5'd16,
		ST_VALUE              = 5'd17,
		ST_LF2                = 5'd18,
		ST_LF3                = 5'd19
	} parse_state_t;

	typedef enum logic [2:0] {
		CLS_FRAMING  = 3'd0,
		CLS_METHOD   = 3'd1,
		CLS_URI      = 3'd2,
		CLS_NEW_NAME = 3'd3,
		CLS_NAME     = 3'd4,
		CLS_VALUE    = 3'd5
	} byte_class_t;

	typedef enum logic [1:0] {
		STAT_PENDING  = 2'd0,
		STAT_COMPLETE = 2'd1,
		STAT_ERROR    = 2'd2
	} status_t;

	localparam logic [7:0] CH_DEL   = 8'd127;
	localparam logic [7:0] CH_CTL   = 8'd31;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_H     = 8'h48;
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] VER_MAX  = 8'd255;

	function automatic logic is_ctl(input logic [7:0] c);
		return (c <= CH_CTL) || (c == CH_DEL);
	endfunction

	function automatic logic is_separator(input logic [7:0] c);
		logic sep;
		unique case (c)
			8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40,
			8'h2C, 8'h3B, 8'h3A, 8'h5C, 8'h22,
			8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D,
			8'h7B, 8'h7D, 8'h20, 8'h09: sep = 1'b1;
			default: sep = 1'b0;
		endcase
		return sep;
	endfunction

	function automatic logic is_token(input logic [7:0] c);
		return !c[7] && !is_ctl(c) && !is_separator(c);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	// value*10 + digit, saturating at 255
	function automatic logic [7:0] add_digit(input logic [7:0] v, input logic [7:0] c);
		logic [11:0] n;
		n = 12'(v) * 12'd10 + 12'(c - CH_ZERO);
		return (n > 12'(VER_MAX)) ? VER_MAX : n[7:0];
	endfunction

endpackage

>>> design/http_request_head_parser.sv
`timescale 1ns / 1ps
// Pipeline: an accepted beat goes to the input register, then through the parse logic
//   into the result register.
// Throughput: one byte per cycle when out_stall is low; the state update is the only loop.
// Reset (arst_n low, asynchronous): parser at method start, versions zero, status pending,
//   both pipeline registers empty.

module http_request_head_parser
	import hrhp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       restart,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] byte_class,
	output logic [1:0] status,
	output logic [7:0] version_major,
	output logic [7:0] version_minor
);

	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         restart_s1;

	logic         out_valid_q;
	byte_class_t  class_q;
	status_t      status_out_q;
	logic [7:0]   major_out_q;
	logic [7:0]   minor_out_q;

	parse_state_t state_q;
	logic         seen_q;
	logic [7:0]   major_q;
	logic [7:0]   minor_q;
	status_t      stat_q;

	logic         out_load;
	logic         s1_load;

	parse_state_t st, nst;
	logic         seen, nseen;
	logic [7:0]   maj, nmaj, mnr, nmnr;
	status_t      stat, nstat;
	byte_class_t  cls;
	logic         bad;
	logic [7:0]   c;

	// Handshake: result register frees when empty or taken
	assign out_load = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !out_load;
	assign s1_load  = in_valid && !in_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_load || out_load) begin
			valid_s1 <= s1_load;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_load) begin
			byte_s1    <= in_byte;
			restart_s1 <= restart;
		end
	end

	// Parse step on the byte in the input register
	always_comb begin
		c     = byte_s1;
		st    = restart_s1 ? ST_METHOD_START : state_q;
		seen  = restart_s1 ? 1'b0 : seen_q;
		maj   = restart_s1 ? 8'd0 : major_q;
		mnr   = restart_s1 ? 8'd0 : minor_q;
		stat  = restart_s1 ? STAT_PENDING : stat_q;
		nst   = st;
		nseen = seen;
		nmaj  = maj;
		nmnr  = mnr;
		nstat = stat;
		cls   = CLS_FRAMING;
		bad   = 1'b0;
		if (stat == STAT_PENDING) begin
			unique case (st)
				ST_METHOD_START: begin
					if (is_token(c)) begin nst = ST_METHOD; cls = CLS_METHOD; end
					else bad = 1'b1;
				end
				ST_METHOD: begin
					if (c == CH_SP) nst = ST_URI;
					else if (is_token(c)) cls = CLS_METHOD;
					else bad = 1'b1;
				end
				ST_URI: begin
					if (c == CH_SP) nst = ST_H;
					else if (!is_ctl(c)) cls = CLS_URI;
					else bad = 1'b1;
				end
				ST_H: begin
					if (c == CH_H) nst = ST_T1;
					else bad = 1'b1;
				end
				ST_T1: begin
					if (c == CH_T) nst = ST_T2;
					else bad = 1'b1;
				end
				ST_T2: begin
					if (c == CH_T) nst = ST_P;
					else bad = 1'b1;
				end
				ST_P: begin
					if (c == CH_P) nst = ST_SLASH;
					else bad = 1'b1;
				end
				ST_SLASH: begin
					if (c == CH_SLASH) begin
						nmaj = 8'd0;
						nmnr = 8'd0;
						nst  = ST_MAJOR_START;
					end else bad = 1'b1;
				end
				ST_MAJOR_START: begin
					if (is_digit(c)) begin nmaj = add_digit(maj, c); nst = ST_MAJOR; end
					else bad = 1'b1;
				end
				ST_MAJOR: begin
					if (c == CH_DOT) nst = ST_MINOR_START;
					else if (is_digit(c)) nmaj = add_digit(maj, c);
					else bad = 1'b1;
				end
				ST_MINOR_START: begin
					if (is_digit(c)) begin nmnr = add_digit(mnr, c); nst = ST_MINOR; end
					else bad = 1'b1;
				end
				ST_MINOR: begin
					if (c == CH_CR) nst = ST_LF1;
					else if (is_digit(c)) nmnr = add_digit(mnr, c);
					else bad = 1'b1;
				end
				ST_LF1, ST_LF2: begin
					if (c == CH_LF) nst = ST_LINE_START;
					else bad = 1'b1;
				end
				ST_LINE_START: begin
					if (c == CH_CR) nst = ST_LF3;
					else if (seen && (c == CH_SP || c == CH_TAB)) nst = ST_LWS;
					else if (is_token(c)) begin
						nseen = 1'b1;
						nst   = ST_NAME;
						cls   = CLS_NEW_NAME;
					end else bad = 1'b1;
				end
				ST_LWS: begin
					if (c == CH_CR) nst = ST_LF2;
					else if (c == CH_SP || c == CH_TAB) nst = ST_LWS;
					else if (!is_ctl(c)) begin nst = ST_VALUE; cls = CLS_VALUE; end
					else bad = 1'b1;
				end
				ST_NAME: begin
					if (c == CH_COLON) nst = ST_SPACE_BEFORE_VALUE;
					else if (is_token(c)) cls = CLS_NAME;
					else bad = 1'b1;
				end
				ST_SPACE_BEFORE_VALUE: begin
					if (c == CH_SP) nst = ST_VALUE;
					else bad = 1'b1;
				end
				ST_VALUE: begin
					if (c == CH_CR) nst = ST_LF2;
					else if (!is_ctl(c)) cls = CLS_VALUE;
					else bad = 1'b1;
				end
				ST_LF3: begin
					if (c == CH_LF) nstat = STAT_COMPLETE;
					else bad = 1'b1;
				end
				default: bad = 1'b1;
			endcase
			// Rejected byte holds state and versions
			if (bad) begin
				nst   = st;
				nseen = seen;
				nmaj  = maj;
				nmnr  = mnr;
				cls   = CLS_FRAMING;
				nstat = STAT_ERROR;
			end
		end
	end

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_METHOD_START;
			seen_q  <= 1'b0;
			major_q <= 8'd0;
			minor_q <= 8'd0;
			stat_q  <= STAT_PENDING;
		end else if (out_load) begin
			state_q <= nst;
			seen_q  <= nseen;
			major_q <= nmaj;
			minor_q <= nmnr;
			stat_q  <= nstat;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load || !out_stall) begin
			out_valid_q <= out_load;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			class_q      <= cls;
			status_out_q <= nstat;
			major_out_q  <= nmaj;
			minor_out_q  <= nmnr;
		end
	end

	assign out_valid     = out_valid_q;
	assign byte_class    = class_q;
	assign status        = status_out_q;
	assign version_major = major_out_q;
	assign version_minor = minor_out_q;

endmodule

>>> design/hrhp_checker.sv
`timescale 1ns / 1ps

module hrhp_checker
	import hrhp_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [7:0] in_byte,
	input logic       restart,
	input logic       out_valid,
	input logic       out_stall,
	input logic [2:0] byte_class,
	input logic [1:0] status,
	input logic [7:0] version_major,
	input logic [7:0] version_minor
);

	// A stalled input beat holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(in_byte) && $stable(restart))
		else $error("stalled input beat changed");

	// A stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(byte_class) && $stable(status)
			&& $stable(version_major) && $stable(version_minor))
		else $error("stalled result beat changed");

	// Input backs up only when the result side is full and stalled
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output backpressure");

	// A non-framing class only comes with a pending status
	a_class_pending: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && byte_class != CLS_FRAMING |-> status == STAT_PENDING)
		else $error("classified byte with final status");

	// Class and status codes stay in range
	a_codes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (byte_class <= CLS_VALUE) && (status == STAT_PENDING
			|| status == STAT_COMPLETE || status == STAT_ERROR))
		else $error("result code out of range");

endmodule

bind http_request_head_parser hrhp_checker u_hrhp_checker (.*);
